@@ rtl/core/dpm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpm_pkg
// Types and constants shared by the binary64 multiplier.
// ----------------------------------------------------------------------------
package dpm_pkg;
   localparam int WordWidth = 64;
   localparam int ExpWidth  = 11;
   localparam int FracWidth = 52;
   localparam int SigWidth  = 53;
   localparam int ProdWidth = 106;
   localparam logic [12:0] ExpBias  = 13'd1023;
   localparam logic [10:0] ExpOnes  = 11'h7FF;
   localparam logic [51:0] HalfWord = 52'h8000000000000;

   typedef struct packed {
      logic [63:0] operand_a;
      logic [63:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [63:0] product;
      logic        invalid_flag;
      logic        overflow_flag;
   } rsp_type;

   // operand facts that travel alongside the arithmetic
   typedef struct packed {
      logic        sign_a;
      logic        sign_b;
      logic        nan_a;
      logic        nan_b;
      logic        mz_a;
      logic        mz_b;
      logic        zero_a;
      logic        zero_b;
      logic        denorm;
      logic [51:0] frac_a;
      logic [51:0] frac_b;
   } flags_type;
endpackage
`default_nettype wire

@@ rtl/core/dpm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpm_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface dpm_if #(parameter type T = logic) (input wire logic clock);
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/dpm_mul53.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpm_mul53
// 53x53 significand multiplier, two stages: four partial products of at most
// 27x27 bits are registered, then summed.
// ----------------------------------------------------------------------------
module dpm_mul53 import dpm_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 enable,
   input  wire logic [SigWidth-1:0]  x,
   input  wire logic [SigWidth-1:0]  y,
   output logic      [ProdWidth-1:0] p
);
   logic [53:0] pll_ff, plh_ff, phl_ff, phh_ff;
   logic [ProdWidth-1:0] p_ff;
   logic [ProdWidth-1:0] sum_in;

   always_ff @(posedge clock) begin
      if (enable) begin
         pll_ff <= {1'b0, x[26:0]} * {1'b0, y[26:0]};
         plh_ff <= {1'b0, x[26:0]} * {1'b0, y[52:27]};
         phl_ff <= {1'b0, x[52:27]} * {1'b0, y[26:0]};
         phh_ff <= {2'b0, x[52:27]} * {2'b0, y[52:27]};
         p_ff   <= sum_in;
      end
   end

   always_comb begin
      sum_in = {52'd0, pll_ff} + ({52'd0, plh_ff} << 27) + ({52'd0, phl_ff} << 27)
             + ({52'd0, phh_ff} << 54);
   end

   assign p = p_ff;
endmodule
`default_nettype wire

@@ rtl/core/double_precision_multiplier.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_precision_multiplier
// Binary64 multiplier with round-to-nearest-even and NaN/overflow flags.
// ----------------------------------------------------------------------------
// Six-stage pipeline, one word per cycle while the output is not stalled. Stages:
// unpack, two multiplier stages, normalise, underflow shift, round/pack. Every
// stage moves whenever the output register is empty or is taken, so a stall
// holds all words in place.
module double_precision_multiplier import dpm_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   dpm_if.sink       req,
   dpm_if.source     rsp
);
   localparam int Stages = 6;

   logic [Stages-1:0] valid_ff;
   logic advance;
   req_type in_w;

   assign in_w = req.data;
   assign advance = !valid_ff[Stages-1] || rsp.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[Stages-2:0], req.valid};
      end
   end

   // stage 1: unpack
   flags_type f1_ff, f2_ff, f3_ff, f4_ff, f5_ff;
   logic [12:0] e1_ff, e2_ff, e3_ff;
   logic [SigWidth-1:0] ma1_ff, mb1_ff;
   flags_type f_in;
   logic [10:0] ea, eb;

   always_comb begin
      ea = in_w.operand_a[62:52];
      eb = in_w.operand_b[62:52];
      f_in.sign_a = in_w.operand_a[63];
      f_in.sign_b = in_w.operand_b[63];
      f_in.nan_a  = ea == ExpOnes;
      f_in.nan_b  = eb == ExpOnes;
      f_in.mz_a   = in_w.operand_a[51:0] == '0;
      f_in.mz_b   = in_w.operand_b[51:0] == '0;
      f_in.zero_a = in_w.operand_a[62:0] == '0;
      f_in.zero_b = in_w.operand_b[62:0] == '0;
      f_in.denorm = ea == '0 || eb == '0;
      f_in.frac_a = in_w.operand_a[51:0];
      f_in.frac_b = in_w.operand_b[51:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_ff  <= f_in;
         e1_ff  <= {2'b0, ea} + {2'b0, eb} - ExpBias;
         ma1_ff <= {ea != '0, in_w.operand_a[51:0]};
         mb1_ff <= {eb != '0, in_w.operand_b[51:0]};
         f2_ff  <= f1_ff;
         e2_ff  <= e1_ff;
         f3_ff  <= f2_ff;
         e3_ff  <= e2_ff;
      end
   end

   // stages 2-3: multiplier
   logic [ProdWidth-1:0] prod;
   dpm_mul53 u_mul (.clock(clock), .enable(advance), .x(ma1_ff), .y(mb1_ff), .p(prod));

   // stage 4: normalise
   logic [6:0]   shift;
   logic [104:0] align;
   logic [12:0]  ealign;
   logic [11:0]  post_in;
   logic [104:0] align4_ff;
   logic [11:0]  post4_ff;
   logic [12:0]  ealign4_ff;

   always_comb begin
      shift = '0;
      for (int i = 0; i < 104; i++) begin
         if (prod[i]) shift = 7'(104 - i);
      end
      if (prod[105] || prod[104]) shift = '0;
      if (prod[105]) align = prod[105:1];
      else align = 105'(prod << shift);
      if (prod[105]) ealign = e3_ff + 13'd1;
      else if (f3_ff.denorm) ealign = e3_ff + 13'd1 - {6'd0, shift};
      else ealign = e3_ff - {6'd0, shift};
      post_in = '0;
      if (ealign[12] || ealign == '0) begin
         if (shift == '0 || prod[105] || f3_ff.denorm) post_in = ~ealign[11:0] + 12'd2;
         else post_in = ~ealign[11:0] + 12'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         align4_ff  <= align;
         post4_ff   <= post_in;
         ealign4_ff <= ealign;
         f4_ff      <= f3_ff;
      end
   end

   // stage 5: underflow right shift
   logic [104:0] ps5_ff;
   logic [12:0]  ealign5_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         ps5_ff     <= (post4_ff < 12'd105) ? (align4_ff >> post4_ff[6:0]) : '0;
         ealign5_ff <= ealign4_ff;
         f5_ff      <= f4_ff;
      end
   end

   // stage 6: round and pack
   rsp_type out_ff, out_in;
   logic [52:0] mshort;
   logic rnd, ovf, sign;
   logic [10:0] expo;
   logic [51:0] mant;

   always_comb begin
      mshort = ps5_ff[104:52];
      rnd = ps5_ff[51] && !(ps5_ff[51:0] == HalfWord && !ps5_ff[52]);
      ovf = !ealign5_ff[12] && ealign5_ff[11:0] >= 12'h7FF;
      if ((f5_ff.nan_a && f5_ff.mz_a && f5_ff.zero_b) ||
          (f5_ff.nan_b && f5_ff.mz_b && f5_ff.zero_a)) sign = 1'b1;
      else if (f5_ff.nan_a && !f5_ff.mz_a) sign = f5_ff.sign_a | f5_ff.sign_b;
      else if (f5_ff.nan_b && !f5_ff.mz_b) sign = f5_ff.sign_b;
      else sign = f5_ff.sign_a ^ f5_ff.sign_b;
      if (f5_ff.nan_a || f5_ff.nan_b) expo = ExpOnes;
      else if (ealign5_ff[11] || f5_ff.zero_a || f5_ff.zero_b) expo = '0;
      else if (ovf) expo = ExpOnes;
      else expo = ealign5_ff[10:0] + {10'd0, (mshort == '1) && rnd};
      if ((f5_ff.nan_a && f5_ff.mz_a && !f5_ff.mz_b) ||
          (f5_ff.nan_b && f5_ff.mz_b && !f5_ff.mz_a) ||
          (!f5_ff.nan_a && !f5_ff.nan_b && ovf)) mant = '0;
      else if (f5_ff.nan_a && !(f5_ff.nan_b && f5_ff.sign_b))
         mant = {1'b1, f5_ff.frac_a[50:0]};
      else if (f5_ff.nan_b) mant = {1'b1, f5_ff.frac_b[50:0]};
      else mant = mshort[51:0] + {51'd0, rnd};
      out_in.product       = {sign, expo, mant};
      out_in.invalid_flag  = f5_ff.nan_a || f5_ff.nan_b;
      out_in.overflow_flag = ovf;
   end

   always_ff @(posedge clock) begin
      if (advance) out_ff <= out_in;
   end

   assign rsp.valid = valid_ff[Stages-1];
   assign rsp.data  = out_ff;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> valid_ff == $past(valid_ff))
      else $error("pipeline moved during stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("input blocked with empty output");
   a_nan_exp: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.invalid_flag |-> rsp.data.product[62:52] == ExpOnes)
      else $error("invalid result without all-ones exponent");
endmodule
`default_nettype wire
